>>> rtl/core/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

  localparam int SLOTS = 256;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  typedef logic [SLOT_AW-1:0] slot_idx_t;

  // Reciprocal of 15 scaled by 2^34; combined with a right shift by two it
  // gives an exact floor division by 60 for magnitudes up to 2^31.
  localparam logic [30:0] DIV15_MAGIC = 31'd1145324613;
  localparam int DIV15_SHIFT = 34;

  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_FORCE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_RUN  = 2'd0,
    PH_FADE = 2'd1,
    PH_DEAD = 2'd2,
    PH_RSVD = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    REG_GRAV_X    = 3'd0,
    REG_GRAV_Y    = 3'd1,
    REG_GRAV_Z    = 3'd2,
    REG_LIFE      = 3'd3,
    REG_FADE_EN   = 3'd4,
    REG_FADE      = 3'd5,
    REG_ALPHA     = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    FEED_G = 2'd0,
    FEED_F = 2'd1,
    FEED_V = 2'd2
  } feed_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIVG,
    ST_DIVF,
    ST_ACCG,
    ST_ACCF,
    ST_DIVV,
    ST_WAITV,
    ST_ACCP,
    ST_MULA,
    ST_DIVA,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic  clr;
    logic  ld;
    logic  load_work;
    feed_e feed;
    logic  acc_g;
    logic  acc_f;
    logic  acc_p;
    logic  mul_a;
    logic  div_step;
    logic  wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic clr_last;
  } dp_status_t;

endpackage

>>> rtl/core/pse_div60.sv
`timescale 1ns / 1ps

module pse_div60 (
  input  logic        clk_i,
  input  logic [31:0] x_i,
  output logic [31:0] q_o
);

  logic        neg_q, neg2_q;
  logic [29:0] mag_q;
  logic [26:0] quo_q;
  logic [31:0] mag;
  logic [60:0] prod;

  assign mag  = x_i[31] ? (~x_i + 32'd1) : x_i;
  assign prod = 61'(mag_q) * 61'(pse_pkg::DIV15_MAGIC);

  always_ff @(posedge clk_i) begin
    neg_q  <= x_i[31];
    mag_q  <= mag[31:2];
    neg2_q <= neg_q;
    quo_q  <= prod[pse_pkg::DIV15_SHIFT+26:pse_pkg::DIV15_SHIFT];
  end

  assign q_o = neg2_q ? (32'd0 - {5'd0, quo_q}) : {5'd0, quo_q};

endmodule

>>> rtl/core/pse_ctrl.sv
`timescale 1ns / 1ps

module pse_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  pse_pkg::dp_status_t    status_i,
  output pse_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy_o
);

  pse_pkg::state_e state_q, state_d;
  logic [4:0]      cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.feed = pse_pkg::FEED_G;
    busy_o  = 1'b1;
    unique case (state_q)
      pse_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = pse_pkg::ST_IDLE;
        end
      end
      pse_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.ld = 1'b1;
          state_d  = pse_pkg::ST_READ;
        end
      end
      pse_pkg::ST_READ: begin
        cmd_o.load_work = 1'b1;
        state_d = status_i.is_tick ? pse_pkg::ST_DIVG : pse_pkg::ST_WRITE;
      end
      pse_pkg::ST_DIVG: begin
        cmd_o.feed = pse_pkg::FEED_G;
        state_d    = pse_pkg::ST_DIVF;
      end
      pse_pkg::ST_DIVF: begin
        cmd_o.feed = pse_pkg::FEED_F;
        state_d    = pse_pkg::ST_ACCG;
      end
      pse_pkg::ST_ACCG: begin
        cmd_o.acc_g = 1'b1;
        state_d     = pse_pkg::ST_ACCF;
      end
      pse_pkg::ST_ACCF: begin
        cmd_o.acc_f = 1'b1;
        state_d     = pse_pkg::ST_DIVV;
      end
      pse_pkg::ST_DIVV: begin
        cmd_o.feed = pse_pkg::FEED_V;
        state_d    = pse_pkg::ST_WAITV;
      end
      pse_pkg::ST_WAITV: begin
        state_d = pse_pkg::ST_ACCP;
      end
      pse_pkg::ST_ACCP: begin
        cmd_o.acc_p = 1'b1;
        state_d     = pse_pkg::ST_MULA;
      end
      pse_pkg::ST_MULA: begin
        cmd_o.mul_a = 1'b1;
        cnt_d       = '0;
        state_d     = pse_pkg::ST_DIVA;
      end
      pse_pkg::ST_DIVA: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == pse_pkg::DIV_LAST) begin
          state_d = pse_pkg::ST_WRITE;
        end
      end
      pse_pkg::ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = pse_pkg::ST_IDLE;
      end
      default: begin
        state_d = pse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/pse_dp.sv
`timescale 1ns / 1ps

module pse_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pse_pkg::ctrl_cmd_t         cmd_i,
  output pse_pkg::dp_status_t        status_o,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_wdata_i,
  input  logic [1:0]                 command_i,
  input  logic [7:0]                 slot_i,
  input  logic signed [31:0]         vec_a_x_i,
  input  logic signed [31:0]         vec_a_y_i,
  input  logic signed [31:0]         vec_a_z_i,
  input  logic signed [31:0]         vec_b_x_i,
  input  logic signed [31:0]         vec_b_y_i,
  input  logic signed [31:0]         vec_b_z_i,
  input  logic signed [31:0]         jitter_x_i,
  input  logic signed [31:0]         jitter_y_i,
  input  logic signed [31:0]         jitter_z_i,
  output logic                       done_o,
  output logic [7:0]                 out_slot_o,
  output logic signed [31:0]         pos_x_o,
  output logic signed [31:0]         pos_y_o,
  output logic signed [31:0]         pos_z_o,
  output logic [15:0]                alpha_o,
  output logic [1:0]                 phase_o
);

  // Configuration registers.
  logic [31:0] grav_q [3];
  logic [15:0] life_q, fade_q, salpha_q;
  logic        fade_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0] <= '0;
      grav_q[1] <= '0;
      grav_q[2] <= '0;
      life_q    <= 16'd60;
      fade_en_q <= 1'b0;
      fade_q    <= 16'd60;
      salpha_q  <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (pse_pkg::reg_e'(cfg_idx_i))
        pse_pkg::REG_GRAV_X:  grav_q[0] <= cfg_wdata_i;
        pse_pkg::REG_GRAV_Y:  grav_q[1] <= cfg_wdata_i;
        pse_pkg::REG_GRAV_Z:  grav_q[2] <= cfg_wdata_i;
        pse_pkg::REG_LIFE:    life_q    <= cfg_wdata_i[15:0];
        pse_pkg::REG_FADE_EN: fade_en_q <= cfg_wdata_i[0];
        pse_pkg::REG_FADE:    fade_q    <= cfg_wdata_i[15:0];
        pse_pkg::REG_ALPHA:   salpha_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Latched input word.
  pse_pkg::cmd_e cmd_q;
  logic [7:0]    slot_q;
  logic [31:0]   a_q [3];
  logic [31:0]   b_q [3];
  logic [31:0]   j_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      cmd_q  <= pse_pkg::cmd_e'(command_i);
      slot_q <= slot_i;
      a_q[0] <= $unsigned(vec_a_x_i);
      a_q[1] <= $unsigned(vec_a_y_i);
      a_q[2] <= $unsigned(vec_a_z_i);
      b_q[0] <= $unsigned(vec_b_x_i);
      b_q[1] <= $unsigned(vec_b_y_i);
      b_q[2] <= $unsigned(vec_b_z_i);
      j_q[0] <= $unsigned(jitter_x_i);
      j_q[1] <= $unsigned(jitter_y_i);
      j_q[2] <= $unsigned(jitter_z_i);
    end
  end

  // Slot counter for the clearing pass after reset.
  pse_pkg::slot_idx_t clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr) begin
      clr_idx_q <= clr_idx_q + pse_pkg::slot_idx_t'(1);
    end
  end

  always_comb begin
    status_o          = '0;
    status_o.is_tick  = (cmd_q == pse_pkg::CMD_TICK);
    status_o.clr_last = (clr_idx_q == pse_pkg::slot_idx_t'(pse_pkg::SLOTS - 1));
  end

  pse_pkg::slot_idx_t rd_idx, wr_idx;
  logic               oor;
  assign rd_idx = pse_pkg::slot_idx_t'(slot_i);
  assign wr_idx = cmd_i.clr ? clr_idx_q : pse_pkg::slot_idx_t'(slot_q);
  assign oor    = 32'(slot_q) >= pse_pkg::SLOTS;

  // Slot memories; age, phase and alpha share one word.
  logic [95:0] pos_mem  [pse_pkg::SLOTS];
  logic [95:0] vel_mem  [pse_pkg::SLOTS];
  logic [95:0] frc_mem  [pse_pkg::SLOTS];
  logic [33:0] meta_mem [pse_pkg::SLOTS];
  logic [95:0] pos_rd_q, vel_rd_q, frc_rd_q;
  logic [33:0] meta_rd_q;

  logic        wr_pv, wr_f, wr_m;
  logic [95:0] pos_wd, vel_wd, frc_wd;
  logic [33:0] meta_wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      pos_rd_q  <= pos_mem[rd_idx];
      vel_rd_q  <= vel_mem[rd_idx];
      frc_rd_q  <= frc_mem[rd_idx];
      meta_rd_q <= meta_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pv) begin
      pos_mem[wr_idx] <= pos_wd;
      vel_mem[wr_idx] <= vel_wd;
    end
    if (wr_f) begin
      frc_mem[wr_idx] <= frc_wd;
    end
    if (wr_m) begin
      meta_mem[wr_idx] <= meta_wd;
    end
  end

  // Working copy of the slot.
  logic [31:0]    pos_w_q [3];
  logic [31:0]    vel_w_q [3];
  logic [31:0]    frc_w_q [3];
  logic [15:0]    age_w_q, alpha_w_q;
  pse_pkg::phase_e phase_w_q;
  logic [31:0]    feed [3];
  logic [31:0]    quo  [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    always_comb begin
      case (cmd_i.feed)
        pse_pkg::FEED_F: feed[k] = frc_w_q[k] + j_q[k];
        pse_pkg::FEED_V: feed[k] = vel_w_q[k];
        default:         feed[k] = grav_q[k];
      endcase
    end

    pse_div60 u_div60 (
      .clk_i (clk_i),
      .x_i   (feed[k]),
      .q_o   (quo[k])
    );

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_work) begin
        pos_w_q[k] <= pos_rd_q[32*k +: 32];
        vel_w_q[k] <= vel_rd_q[32*k +: 32];
        frc_w_q[k] <= frc_rd_q[32*k +: 32];
      end else if (cmd_i.acc_g || cmd_i.acc_f) begin
        vel_w_q[k] <= vel_w_q[k] + quo[k];
      end else if (cmd_i.acc_p) begin
        pos_w_q[k] <= pos_w_q[k] + quo[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      age_w_q   <= meta_rd_q[33:18];
      phase_w_q <= pse_pkg::phase_e'(meta_rd_q[17:16]);
      alpha_w_q <= meta_rd_q[15:0];
    end
  end

  // Age and fade arithmetic.
  logic [15:0] age_inc, fade_t;
  logic [31:0] fade_prod;
  assign age_inc   = (age_w_q == 16'hFFFF) ? age_w_q : age_w_q + 16'd1;
  assign fade_t    = (fade_q == 16'd0) ? 16'd1 : fade_q;
  assign fade_prod = 32'(salpha_q) * 32'(fade_t - age_inc);

  // Restoring divider: the dividend register shifts out and takes in quotient bits.
  logic [31:0] dvd_q;
  logic [16:0] rem_q;
  logic [16:0] rem_sh;
  logic        fits;
  assign rem_sh = {rem_q[15:0], dvd_q[31]};
  assign fits   = rem_sh >= {1'b0, fade_t};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      dvd_q <= fade_prod;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? (rem_sh - {1'b0, fade_t}) : rem_sh;
      dvd_q <= {dvd_q[30:0], fits};
    end
  end

  // New age, phase and alpha after a tick.
  logic [15:0]     age_n, alpha_n;
  pse_pkg::phase_e phase_n;

  always_comb begin
    age_n   = age_inc;
    phase_n = phase_w_q;
    alpha_n = alpha_w_q;
    case (phase_w_q)
      pse_pkg::PH_RUN: begin
        if (age_inc >= life_q) begin
          if (fade_en_q) begin
            phase_n = pse_pkg::PH_FADE;
            age_n   = '0;
          end else begin
            phase_n = pse_pkg::PH_DEAD;
          end
        end
      end
      pse_pkg::PH_FADE: begin
        if (age_inc >= fade_t || salpha_q == 16'd0) begin
          alpha_n = '0;
          phase_n = pse_pkg::PH_DEAD;
        end else begin
          alpha_n = dvd_q[15:0];
        end
      end
      default: ;
    endcase
  end

  logic is_spawn, is_force, is_tick;
  assign is_spawn = (cmd_q == pse_pkg::CMD_SPAWN);
  assign is_force = (cmd_q == pse_pkg::CMD_FORCE);
  assign is_tick  = (cmd_q == pse_pkg::CMD_TICK);

  // The clearing pass zeroes the force and marks every slot dead.
  assign wr_pv = cmd_i.wr && !oor && (is_spawn || is_tick);
  assign wr_f  = (cmd_i.wr && !oor && (is_force || is_tick)) || cmd_i.clr;
  assign wr_m  = wr_pv || cmd_i.clr;

  assign pos_wd = is_spawn ? {a_q[2], a_q[1], a_q[0]}
                           : {pos_w_q[2], pos_w_q[1], pos_w_q[0]};
  assign vel_wd = is_spawn ? {b_q[2], b_q[1], b_q[0]}
                           : {vel_w_q[2], vel_w_q[1], vel_w_q[0]};
  assign frc_wd = (is_force && !cmd_i.clr) ? {a_q[2], a_q[1], a_q[0]} : 96'd0;
  assign meta_wd = cmd_i.clr ? {16'd0, pse_pkg::PH_DEAD, 16'd0}
                 : is_spawn  ? {16'd0, pse_pkg::PH_RUN, salpha_q}
                             : {age_n, phase_n, alpha_n};

  // Result registers.
  logic        done_q;
  logic [7:0]  oslot_q;
  logic [31:0] opos_q [3];
  logic [15:0] oalpha_q;
  logic [1:0]  ophase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      oslot_q <= slot_q;
      if (oor) begin
        opos_q[0] <= '0;
        opos_q[1] <= '0;
        opos_q[2] <= '0;
        oalpha_q  <= '0;
        ophase_q  <= pse_pkg::PH_DEAD;
      end else if (is_spawn) begin
        opos_q[0] <= a_q[0];
        opos_q[1] <= a_q[1];
        opos_q[2] <= a_q[2];
        oalpha_q  <= salpha_q;
        ophase_q  <= pse_pkg::PH_RUN;
      end else begin
        opos_q[0] <= pos_w_q[0];
        opos_q[1] <= pos_w_q[1];
        opos_q[2] <= pos_w_q[2];
        oalpha_q  <= is_tick ? alpha_n : alpha_w_q;
        ophase_q  <= is_tick ? phase_n : phase_w_q;
      end
    end
  end

  assign done_o     = done_q;
  assign out_slot_o = oslot_q;
  assign pos_x_o    = $signed(opos_q[0]);
  assign pos_y_o    = $signed(opos_q[1]);
  assign pos_z_o    = $signed(opos_q[2]);
  assign alpha_o    = oalpha_q;
  assign phase_o    = ophase_q;

endmodule

>>> rtl/core/particle_step_engine.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// command   start_i, busy_o, command_i .. jitter_z_i word taken when start_i && !busy_o
// result    done_o, out_slot_o .. phase_o            one-cycle strobe on done_o
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i         written when cfg_we_i is high
//
// A tick word goes from acceptance to its result strobe through a memory read,
// three passes through the divide-by-60 lanes, then a 32-step restoring divider
// for the fade level. Spawn, force and unused words skip to the write after the read.
// The next word may be accepted in the cycle of the strobe.
// Reset restores the configuration defaults; then a pass over all 256 slots, one slot per
// cycle, zeroes every pending force and marks every slot dead, with busy_o high.
// The receiver cannot stall; each result is shown for one cycle only.

module particle_step_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          slot_i,
  input  logic signed [31:0]  vec_a_x_i,
  input  logic signed [31:0]  vec_a_y_i,
  input  logic signed [31:0]  vec_a_z_i,
  input  logic signed [31:0]  vec_b_x_i,
  input  logic signed [31:0]  vec_b_y_i,
  input  logic signed [31:0]  vec_b_z_i,
  input  logic signed [31:0]  jitter_x_i,
  input  logic signed [31:0]  jitter_y_i,
  input  logic signed [31:0]  jitter_z_i,
  output logic                done_o,
  output logic [7:0]          out_slot_o,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic [15:0]         alpha_o,
  output logic [1:0]          phase_o
);

  pse_pkg::ctrl_cmd_t  ctrl_cmd;
  pse_pkg::dp_status_t dp_status;

  pse_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd),
    .busy_o   (busy_o)
  );

  pse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .command_i   (command_i),
    .slot_i      (slot_i),
    .vec_a_x_i   (vec_a_x_i),
    .vec_a_y_i   (vec_a_y_i),
    .vec_a_z_i   (vec_a_z_i),
    .vec_b_x_i   (vec_b_x_i),
    .vec_b_y_i   (vec_b_y_i),
    .vec_b_z_i   (vec_b_z_i),
    .jitter_x_i  (jitter_x_i),
    .jitter_y_i  (jitter_y_i),
    .jitter_z_i  (jitter_z_i),
    .done_o      (done_o),
    .out_slot_o  (out_slot_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .alpha_o     (alpha_o),
    .phase_o     (phase_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("engine not busy after accepting a word");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result strobes in a row");

endmodule

>>> sim/particle_step_engine_tb.sv
`timescale 1ns / 1ps

module particle_step_engine_tb;

  typedef struct {
    pse_pkg::cmd_e      cmd;
    logic [7:0]         slot;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] j [3];
  } word_t;

  typedef struct {
    logic [7:0]  slot;
    logic [31:0] pos [3];
    logic [15:0] alpha;
    logic [1:0]  phase;
  } particle_t;

  // Particle table mirror: works out the expected slot view for each word.
  class particle_scoreboard;
    logic [31:0]     gravity [3];
    logic [15:0]     life_ticks, fade_ticks, start_alpha;
    logic            fade_en;
    logic [31:0]     pos [256][3];
    logic [31:0]     vel [256][3];
    logic [31:0]     force_acc [256][3];
    logic [15:0]     age [256];
    logic [15:0]     alpha [256];
    pse_pkg::phase_e phase [256];
    particle_t       pending_q [$];
    int              errors;

    function new();
      for (int k = 0; k < 3; k++) gravity[k] = '0;
      life_ticks = 16'd60; fade_ticks = 16'd60; start_alpha = 16'hFFFF; fade_en = 1'b0;
      for (int s = 0; s < 256; s++) begin
        for (int k = 0; k < 3; k++) begin
          pos[s][k] = '0; vel[s][k] = '0; force_acc[s][k] = '0;
        end
        age[s] = '0; alpha[s] = '0; phase[s] = pse_pkg::PH_DEAD;
      end
      errors = 0;
    endfunction

    function automatic logic [31:0] div60(logic [31:0] v);
      int q;
      q = $signed(v) / 60;
      return q;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(pse_pkg::reg_e idx, logic [31:0] d);
      case (idx)
        pse_pkg::REG_GRAV_X:  gravity[0] = d;
        pse_pkg::REG_GRAV_Y:  gravity[1] = d;
        pse_pkg::REG_GRAV_Z:  gravity[2] = d;
        pse_pkg::REG_LIFE:    life_ticks = d[15:0];
        pse_pkg::REG_FADE_EN: fade_en = d[0];
        pse_pkg::REG_FADE:    fade_ticks = d[15:0];
        pse_pkg::REG_ALPHA:   start_alpha = d[15:0];
        default: ;
      endcase
    endfunction

    function void note(word_t w);
      particle_t   r;
      logic [31:0] v, ft, ag;
      int          s;
      s = int'(w.slot);
      case (w.cmd)
        pse_pkg::CMD_SPAWN: begin
          for (int k = 0; k < 3; k++) begin
            pos[s][k] = w.a[k]; vel[s][k] = w.b[k];
          end
          phase[s] = pse_pkg::PH_RUN; alpha[s] = start_alpha; age[s] = '0;
        end
        pse_pkg::CMD_FORCE: for (int k = 0; k < 3; k++) force_acc[s][k] = w.a[k];
        pse_pkg::CMD_TICK: begin
          for (int k = 0; k < 3; k++) begin
            v = vel[s][k] + div60(gravity[k]);
            v = v + div60(force_acc[s][k] + w.j[k]);
            vel[s][k] = v;
            pos[s][k] = pos[s][k] + div60(v);
            force_acc[s][k] = '0;
          end
          if (age[s] != 16'hFFFF) age[s]++;
          if (phase[s] == pse_pkg::PH_RUN) begin
            if (age[s] >= life_ticks) begin
              if (fade_en) begin
                phase[s] = pse_pkg::PH_FADE; age[s] = '0;
              end else begin
                phase[s] = pse_pkg::PH_DEAD;
              end
            end
          end else if (phase[s] == pse_pkg::PH_FADE) begin
            ft = (fade_ticks == 0) ? 32'd1 : {16'd0, fade_ticks};
            ag = {16'd0, age[s]};
            if (ag >= ft || start_alpha == 0) begin
              alpha[s] = '0; phase[s] = pse_pkg::PH_DEAD;
            end else begin
              alpha[s] = 16'(({16'd0, start_alpha} * (ft - ag)) / ft);
            end
          end
        end
        default: ;
      endcase
      r.slot = w.slot;
      for (int k = 0; k < 3; k++) r.pos[k] = pos[s][k];
      r.alpha = alpha[s];
      r.phase = phase[s];
      pending_q.push_back(r);
    endfunction

    task check(particle_t got);
      particle_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("result for slot %0d with nothing expected", got.slot));
        return;
      end
      e = pending_q.pop_front();
      if (got.slot !== e.slot)
        report($sformatf("slot got %0d exp %0d", got.slot, e.slot));
      for (int k = 0; k < 3; k++)
        if (got.pos[k] !== e.pos[k])
          report($sformatf("slot %0d pos[%0d] got %h exp %h", e.slot, k, got.pos[k],
                           e.pos[k]));
      if (got.alpha !== e.alpha)
        report($sformatf("slot %0d alpha got %0d exp %0d", e.slot, got.alpha, e.alpha));
      if (got.phase !== e.phase)
        report($sformatf("slot %0d phase got %0d exp %0d", e.slot, got.phase, e.phase));
    endtask
  endclass

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               start_i, busy_o, done_o;
  logic [1:0]         command_i;
  logic [7:0]         slot_i, out_slot_o;
  logic signed [31:0] vec_a_x_i, vec_a_y_i, vec_a_z_i;
  logic signed [31:0] vec_b_x_i, vec_b_y_i, vec_b_z_i;
  logic signed [31:0] jitter_x_i, jitter_y_i, jitter_z_i;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [15:0]        alpha_o;
  logic [1:0]         phase_o;

  particle_scoreboard sb;
  logic [7:0] pool [8];
  bit         no_gaps;

  particle_step_engine DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    particle_t got;
    if (rst_ni && done_o) begin
      got.slot = out_slot_o;
      got.pos[0] = pos_x_o; got.pos[1] = pos_y_o; got.pos[2] = pos_z_o;
      got.alpha = alpha_o;
      got.phase = phase_o;
      sb.check(got);
    end
  end

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3: return $signed($urandom_range(0, 2 * 2 ** 20)) - 2 ** 20;
      default: return $urandom;
    endcase
  endfunction

  // Keeps start_i high: the caller either sends again or lowers it in a gap.
  task send(pse_pkg::cmd_e c, logic [7:0] s, logic [31:0] ax, ay, az, bx, by, bz, jx,
            jy, jz);
    word_t w;
    w.cmd = c; w.slot = s;
    w.a[0] = ax; w.a[1] = ay; w.a[2] = az;
    w.b[0] = bx; w.b[1] = by; w.b[2] = bz;
    w.j[0] = jx; w.j[1] = jy; w.j[2] = jz;
    start_i <= 1'b1; command_i <= c; slot_i <= s;
    vec_a_x_i <= ax; vec_a_y_i <= ay; vec_a_z_i <= az;
    vec_b_x_i <= bx; vec_b_y_i <= by; vec_b_z_i <= bz;
    jitter_x_i <= jx; jitter_y_i <= jy; jitter_z_i <= jz;
    do @(posedge clk_i); while (busy_o);
    sb.note(w);
  endtask

  task send_random(pse_pkg::cmd_e c, logic [7:0] s);
    send(c, s, rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
         rand_q16(), rand_q16(), rand_q16());
  endtask

  task pause(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task maybe_gap();
    if (!no_gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 12));
  endtask

  task drain();
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task write_reg(pse_pkg::reg_e idx, logic [31:0] d);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  task configure(logic [31:0] gx, gy, gz, logic [15:0] life, logic fen, logic [15:0] fade,
                 logic [15:0] alp);
    write_reg(pse_pkg::REG_GRAV_X, gx);
    write_reg(pse_pkg::REG_GRAV_Y, gy);
    write_reg(pse_pkg::REG_GRAV_Z, gz);
    write_reg(pse_pkg::REG_LIFE, {16'd0, life});
    write_reg(pse_pkg::REG_FADE_EN, {31'd0, fen});
    write_reg(pse_pkg::REG_FADE, {16'd0, fade});
    write_reg(pse_pkg::REG_ALPHA, {16'd0, alp});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int r;
    pse_pkg::cmd_e c;
    logic [7:0] s;
    sb = new();
    no_gaps = 1'b0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    start_i = 1'b0; command_i = pse_pkg::CMD_NOP; slot_i = '0;
    vec_a_x_i = '0; vec_a_y_i = '0; vec_a_z_i = '0;
    vec_b_x_i = '0; vec_b_y_i = '0; vec_b_z_i = '0;
    jitter_x_i = '0; jitter_y_i = '0; jitter_z_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme vectors, every command, a full run-fade-dead life.
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFC4, 16'd2, 1'b1, 16'd3, 16'hFFFF);
    send(pse_pkg::CMD_SPAWN, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000,
         32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    send(pse_pkg::CMD_SPAWN, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
         32'h7FFF_FFFF, 32'h8000_0000, 32'd59, 0, 0, 0);
    send(pse_pkg::CMD_FORCE, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFC5, 0, 0, 0,
         0, 0, 0);
    send(pse_pkg::CMD_SPAWN, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000,
         32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    send(pse_pkg::CMD_TICK, 8'd0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
         32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++)
      send(pse_pkg::CMD_TICK, 8'd0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF,
           32'd60);
    send(pse_pkg::CMD_NOP, 8'd255, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    send(pse_pkg::CMD_FORCE, 8'd255, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0,
         0, 0, 0, 0);
    send(pse_pkg::CMD_TICK, 8'd255, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000);
    drain();
    // Life of zero without fading: dies on the first tick.
    configure(0, 0, 0, 16'd0, 1'b0, 16'd0, 16'd0);
    send(pse_pkg::CMD_SPAWN, 8'd170, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 0, 0, 0);
    send(pse_pkg::CMD_TICK, 8'd170, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(pse_pkg::CMD_SPAWN, 8'd85, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 0, 0, 0);
    drain();
    // Fading with zero start alpha and zero fade length.
    configure(0, 0, 0, 16'd0, 1'b1, 16'd0, 16'd0);
    send(pse_pkg::CMD_SPAWN, 8'd85, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(pse_pkg::CMD_TICK, 8'd85, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(pse_pkg::CMD_TICK, 8'd85, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      logic [15:0] life, fade, alp;
      case (ph)
        0: begin life = 16'd65535; fade = 16'd65535; alp = 16'hFFFF; end
        1: begin life = 16'd1; fade = 16'd1; alp = 16'd1; end
        2: begin life = 16'd0; fade = 16'd0; alp = 16'hFFFF; end
        default: begin
          life = 16'($urandom_range(0, 12)); fade = 16'($urandom_range(0, 16));
          alp = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
        end
      endcase
      configure(rand_q16(), rand_q16(), rand_q16(), life, (ph % 4) != 0, fade, alp);
      no_gaps = (ph == 7);
      for (int k = 0; k < 8; k++) begin
        pool[k] = 8'($urandom);
        send_random(pse_pkg::CMD_SPAWN, pool[k]);
      end
      for (int i = 0; i < 125; i++) begin
        r = $urandom_range(0, 99);
        s = pool[3'($urandom_range(0, 7))];
        if (r < 12) c = pse_pkg::CMD_SPAWN;
        else if (r < 27) c = pse_pkg::CMD_FORCE;
        else if (r < 94) c = pse_pkg::CMD_TICK;
        else c = pse_pkg::CMD_NOP;
        if (c == pse_pkg::CMD_SPAWN && $urandom_range(0, 2) == 0) begin
          s = 8'($urandom);
          pool[3'($urandom_range(0, 7))] = s;
        end
        send_random(c, s);
        if (ph == 4 && i == 60) begin
          // Hold the next word back until the engine has caught up completely.
          start_i <= 1'b0;
          while (sb.pending_q.size() != 0) @(posedge clk_i);
        end
        maybe_gap();
      end
      drain();
    end

    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> particle_step_engine.f
rtl/core/pse_pkg.sv
rtl/core/pse_div60.sv
rtl/core/pse_ctrl.sv
rtl/core/pse_dp.sv
rtl/core/particle_step_engine.sv
sim/particle_step_engine_tb.sv
